/* src/ncs_pkg.sv */
// Shared types and constants for the nearest calibrated code search block.
// No dependencies; used by ncs_ctrl, ncs_dpath and nearest_calibrated_code_search.
package ncs_pkg;

    localparam int IDX_W      = 7;    // entry_index / best_code field width
    localparam int MV_W       = 16;   // millivolt field width
    localparam int S_TDATA_W  = 24;   // entry_index + millivolts, padded to bytes
    localparam int M_TDATA_W  = 24;   // best_code + achieved_mv, padded to bytes

    // mode codes carried in s_axis_tuser
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // status codes carried in m_axis_tuser
    localparam logic STATUS_FOUND    = 1'b0;
    localparam logic STATUS_NO_TABLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;     // store the accepted write word
        logic start;     // accepted lookup: load target, clear scan counter
        logic scan;      // read one table entry, advance counter
        logic load_out;  // move finished result into output register
    } ncs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic table_valid;
        logic scan_last;  // counter sits on the last code
        logic out_free;   // output register empty or being taken
    } ncs_stat_t;

endpackage

/* src/ncs_ctrl.sv */
// Controller state machine for the nearest calibrated code search.
// Depends on ncs_pkg (state_t, ncs_cmd_t, ncs_stat_t, mode codes).
module ncs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_mode,
    input  ncs_pkg::ncs_stat_t stat,
    output logic              in_ready,
    output ncs_pkg::ncs_cmd_t  cmd
);

    ncs_pkg::state_t state_reg;
    ncs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ncs_pkg::ST_IDLE:
            begin
                if (in_valid && (in_mode == ncs_pkg::MODE_LOOKUP))
                begin
                    state_next = stat.table_valid ? ncs_pkg::ST_SCAN : ncs_pkg::ST_DONE;
                end
            end
            ncs_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ncs_pkg::ST_DRAIN;
                end
            end
            ncs_pkg::ST_DRAIN:
            begin
                state_next = ncs_pkg::ST_DONE;
            end
            ncs_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ncs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ncs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.start    = 1'b0;
        cmd.scan     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ncs_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.wr_en = in_valid && (in_mode == ncs_pkg::MODE_WRITE);
                cmd.start = in_valid && (in_mode == ncs_pkg::MODE_LOOKUP);
            end
            ncs_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ncs_pkg::ST_DRAIN:
            begin
            end
            ncs_pkg::ST_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* src/ncs_dpath.sv */
// Datapath for the nearest calibrated code search: table memory, scan
// counter, nearest-entry compare and output register. Depends on ncs_pkg.
module ncs_dpath
#(
    parameter int MAX_CODE = 127
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ncs_pkg::ncs_cmd_t             cmd,
    input  logic [ncs_pkg::IDX_W-1:0]     wr_index,
    input  logic [ncs_pkg::MV_W-1:0]      wr_mv,       // entry on write, target on lookup
    input  logic                          wr_complete,
    input  logic                          out_ready,
    output ncs_pkg::ncs_stat_t            stat,
    output logic                          out_valid,
    output logic [ncs_pkg::IDX_W-1:0]     out_code,
    output logic [ncs_pkg::MV_W-1:0]      out_mv,
    output logic                          out_status
);

    localparam int DEPTH  = MAX_CODE + 1;
    localparam int CODE_W = $clog2(DEPTH);

    logic [ncs_pkg::MV_W-1:0] mem [DEPTH];

    logic                     valid_reg;
    logic                     no_table_reg;
    logic [ncs_pkg::MV_W-1:0] target_reg;
    logic [CODE_W-1:0]        addr_reg;
    logic [ncs_pkg::MV_W-1:0] rd_data_reg;
    logic [CODE_W-1:0]        rd_code_reg;
    logic                     rd_ok_reg;
    logic [ncs_pkg::MV_W-1:0] best_err_reg;
    logic [CODE_W-1:0]        best_code_reg;
    logic [ncs_pkg::MV_W-1:0] best_mv_reg;
    logic                     out_valid_reg;
    logic [ncs_pkg::IDX_W-1:0] out_code_reg;
    logic [ncs_pkg::MV_W-1:0] out_mv_reg;
    logic                     out_status_reg;

    logic                     idx_in_range;
    logic [ncs_pkg::MV_W-1:0] err;
    logic                     take;

    assign idx_in_range = (32'(wr_index) < 32'(DEPTH));

    // single-port style table: one write from the input, one scan read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && idx_in_range)
        begin
            mem[CODE_W'(wr_index)] <= wr_mv;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_code_reg <= addr_reg;
        end
    end

    always_comb
    begin
        err  = (target_reg >= rd_data_reg) ? (target_reg - rd_data_reg)
                                           : (rd_data_reg - target_reg);
        // strict less keeps the lowest code on ties; code 0 seeds the search
        take = (rd_code_reg == '0) || (err < best_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            if (cmd.wr_en && wr_complete)
            begin
                valid_reg <= 1'b1;
            end
            rd_ok_reg <= cmd.scan;
            if (cmd.start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            target_reg   <= wr_mv;
            no_table_reg <= !valid_reg;
        end
        if (rd_ok_reg && take)
        begin
            best_err_reg  <= err;
            best_code_reg <= rd_code_reg;
            best_mv_reg   <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            if (no_table_reg)
            begin
                out_code_reg   <= '0;
                out_mv_reg     <= '0;
                out_status_reg <= ncs_pkg::STATUS_NO_TABLE;
            end
            else
            begin
                out_code_reg   <= ncs_pkg::IDX_W'(best_code_reg);
                out_mv_reg     <= best_mv_reg;
                out_status_reg <= ncs_pkg::STATUS_FOUND;
            end
        end
    end

    assign stat.table_valid = valid_reg;
    assign stat.scan_last   = (addr_reg == CODE_W'(MAX_CODE));
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_code   = out_code_reg;
    assign out_mv     = out_mv_reg;
    assign out_status = out_status_reg;

endmodule

/* src/nearest_calibrated_code_search.sv */
// Nearest calibrated code search: holds a table of measured millivolts per
// wiper code and returns the code nearest a target voltage.
// A write word (tuser = 0) stores one entry at entry_index; tlast set on a
// write marks the table complete, and only reset clears that flag again. Writes
// to an index above MAX_CODE are dropped but still honor tlast. A lookup word
// (tuser = 1) carries a target; the result gives the lowest code with the
// smallest absolute difference and its stored millivolts, status 0. Without a
// complete table the result is code 0, 0 mV, status 1. Writes stream back to
// back. A lookup scans the table memory one entry per cycle through its single
// read port and then moves the result into the output register once that is
// free; a lookup without a complete table skips the scan. The next word is
// taken after that move. The input is not taken during a scan. A result
// waiting in the output register holds back the next lookup's result, and
// with it the input, until the waiting word is taken. Entries must be written
// before a lookup reads them.
// Depends on ncs_pkg, ncs_ctrl and ncs_dpath.
module nearest_calibrated_code_search
#(
    parameter int MAX_CODE = 127
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ncs_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // entry_index[6:0], millivolts[22:7], pad
    input  logic                              s_axis_tuser,  // mode
    input  logic                              s_axis_tlast,  // table_complete
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ncs_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // best_code[6:0], achieved_mv[22:7], pad
    output logic                              m_axis_tuser   // status
);

    ncs_pkg::ncs_cmd_t  cmd;
    ncs_pkg::ncs_stat_t stat;

    logic [ncs_pkg::IDX_W-1:0] in_index;
    logic [ncs_pkg::MV_W-1:0]  in_mv;
    logic [ncs_pkg::IDX_W-1:0] res_code;
    logic [ncs_pkg::MV_W-1:0]  res_mv;

    // unpack input word; the pad bit is ignored
    assign in_index = s_axis_tdata[ncs_pkg::IDX_W-1:0];
    assign in_mv    = s_axis_tdata[ncs_pkg::IDX_W+ncs_pkg::MV_W-1:ncs_pkg::IDX_W];

    ncs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    ncs_dpath #(
        .MAX_CODE (MAX_CODE)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .wr_index    (in_index),
        .wr_mv       (in_mv),
        .wr_complete (s_axis_tlast),
        .out_ready   (m_axis_tready),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_code    (res_code),
        .out_mv      (res_mv),
        .out_status  (m_axis_tuser)
    );

    // pack result word, pad bit zero
    assign m_axis_tdata = {1'b0, res_mv, res_code};

endmodule
